// ===== rtl/core/sfeq_pkg.sv =====
package sfeq_pkg;

  // Filter geometry
  localparam int TAP_COUNT    = 24;
  localparam int SAMPLE_WIDTH = 16;
  localparam int TAP_IDX_W    = $clog2(TAP_COUNT);
  localparam int COEF_W       = 16;
  localparam int PROD_W       = COEF_W + SAMPLE_WIDTH;
  localparam int ACC_W        = 32;

  // Rescale
  localparam int SHIFT_A  = 15;
  localparam int SHIFT_B  = 13;
  localparam int GAIN_W   = 15;
  localparam int OUT_W    = 16;
  localparam int HEAD_W   = ACC_W - SHIFT_A;
  localparam int SCALED_W = HEAD_W + GAIN_W + 1;
  localparam int Y_W      = SCALED_W - SHIFT_B;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_GAIN = 2'd0,
    CFG_CLAMP_MIN   = 2'd1,
    CFG_CLAMP_MAX   = 2'd2
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0]        GAIN_RESET = 15'd13300;
  localparam logic signed [OUT_W-1:0]  CMIN_RESET = -16'sd32768;
  localparam logic [OUT_W-2:0]         CMAX_RESET = 15'd32767;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_GAIN,
    ST_CLAMP
  } state_t;

  // Controls from the sequencer to the arithmetic unit
  typedef struct packed {
    logic clear;
    logic mac_en;
    logic drain;
    logic scale;
  } ctl_t;

  // Coefficient for the tap k samples back from the newest one
  function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_IDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    case (k)
      TAP_IDX_W'(0): c = 16'sd74;
      TAP_IDX_W'(1): c = 16'sd231;
      TAP_IDX_W'(2): c = -16'sd6883;
      TAP_IDX_W'(3): c = 16'sd32767;
      TAP_IDX_W'(4): c = -16'sd6883;
      TAP_IDX_W'(5): c = 16'sd231;
      TAP_IDX_W'(6): c = 16'sd74;
      default:       c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/speaker_fir_equalizer_core.sv =====
// 24-tap fixed-coefficient FIR speaker equaliser. One signed 16-bit sample
// goes in per item on s_axis (tlast marks frame end and is copied through),
// one saturated sample comes out per item on m_axis. For each item the
// delay line, a ring of 24 cells, rotates once past a single multiply-
// accumulate unit (one tap per cycle), followed by a drain, a gain and a
// clamp step. The next item is taken once the clamp step has handed its
// result to the output register, so items are not overlapped and the clamp
// step waits while the output side stalls. The delay line is cleared by reset
// only and runs on across frames. Registers on the cfg port: 0 output gain
// (Q13, 15 bits), 1 saturation floor (signed 16 bits), 2 saturation ceiling
// (15 bits); write them only while no item is in flight.
module speaker_fir_equalizer_core
  import sfeq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // s_axis_tdata: [15:0] sample_in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,
  input  logic                  s_axis_tlast,
  // m_axis_tdata: [15:0] sample_out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t                   state, state_next;
  logic [TAP_IDX_W-1:0]     cnt, cnt_next;
  ctl_t                     ctl;
  logic                     accept;
  logic                     load_out;
  logic                     frame_end;
  logic [GAIN_W-1:0]        output_gain;
  logic signed [OUT_W-1:0]  clamp_min;
  logic [OUT_W-2:0]         clamp_max;
  logic signed [OUT_W-1:0]  result;
  logic signed [SAMPLE_WIDTH-1:0] tap [TAP_COUNT];
  logic signed [SAMPLE_WIDTH-1:0] new_sample;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign new_sample = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign cfg_ready  = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      output_gain <= GAIN_RESET;
      clamp_min   <= CMIN_RESET;
      clamp_max   <= CMAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OUTPUT_GAIN: output_gain <= cfg_data[GAIN_W-1:0];
        CFG_CLAMP_MIN:   clamp_min   <= $signed(cfg_data);
        CFG_CLAMP_MAX:   clamp_max   <= cfg_data[OUT_W-2:0];
        default:         ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    ctl           = '0;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctl.clear     = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_MAC;
          cnt_next   = '0;
        end
      end
      ST_MAC: begin
        ctl.mac_en = 1'b1;
        if (cnt == TAP_IDX_W'(TAP_COUNT - 1)) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        ctl.drain  = 1'b1;
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        ctl.scale  = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Ring of delay cells: shift in on a new item, rotate past the MAC after
  for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
    localparam int NEXT = (i + 1) % TAP_COUNT;
    logic signed [SAMPLE_WIDTH-1:0] shift_src;
    if (i == 0) begin : g_head
      assign shift_src = new_sample;
    end else begin : g_body
      assign shift_src = tap[i-1];
    end
    sfeq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (accept),
      .rotate    (ctl.mac_en),
      .shift_in  (shift_src),
      .rotate_in (tap[NEXT]),
      .value     (tap[i])
    );
  end

  sfeq_mac u_mac (
    .clk         (clk),
    .ctl         (ctl),
    .tap_idx     (cnt),
    .head        (tap[0]),
    .output_gain (output_gain),
    .clamp_min   (clamp_min),
    .clamp_max   (clamp_max),
    .result      (result)
  );

  // Hold the frame marker for the item in flight
  always_ff @(posedge clk) begin
    if (accept) frame_end <= s_axis_tlast;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= result;
      m_axis_tlast <= frame_end;
    end
  end

endmodule

// ===== rtl/core/sfeq_cell.sv =====
module sfeq_cell
  import sfeq_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic                           rotate,
  input  logic signed [SAMPLE_WIDTH-1:0] shift_in,
  input  logic signed [SAMPLE_WIDTH-1:0] rotate_in,
  output logic signed [SAMPLE_WIDTH-1:0] value
);

  // Take the younger neighbour on a new item, the older one while rotating
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (load) begin
      value <= shift_in;
    end else if (rotate) begin
      value <= rotate_in;
    end
  end

endmodule

// ===== rtl/core/sfeq_mac.sv =====
module sfeq_mac
  import sfeq_pkg::*;
(
  input  logic                           clk,
  input  ctl_t                           ctl,
  input  logic [TAP_IDX_W-1:0]           tap_idx,
  input  logic signed [SAMPLE_WIDTH-1:0] head,
  input  logic [GAIN_W-1:0]              output_gain,
  input  logic signed [OUT_W-1:0]        clamp_min,
  input  logic [OUT_W-2:0]               clamp_max,
  output logic signed [OUT_W-1:0]        result
);

  logic signed [PROD_W-1:0]   prod;
  logic                       prod_valid;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [HEAD_W-1:0]   acc_hi;
  logic signed [Y_W-1:0]      y;
  logic signed [Y_W-1:0]      lo_lim;
  logic signed [Y_W-1:0]      hi_lim;
  logic signed [Y_W-1:0]      y_sat;

  // Multiply the head tap by its coefficient, then accumulate modulo 2^32
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      if (ctl.mac_en) begin
        prod <= tap_coef(tap_idx) * head;
      end
      prod_valid <= ctl.mac_en;
      if ((ctl.mac_en || ctl.drain) && prod_valid) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // Drop fifteen fraction bits and apply the gain
  assign acc_hi = acc[ACC_W-1:SHIFT_A];

  always_ff @(posedge clk) begin
    if (ctl.scale) begin
      scaled <= acc_hi * $signed({1'b0, output_gain});
    end
  end

  // Floor first, ceiling last
  assign y      = scaled[SCALED_W-1:SHIFT_B];
  assign lo_lim = Y_W'(clamp_min);
  assign hi_lim = $signed(Y_W'({1'b0, clamp_max}));

  always_comb begin
    y_sat = y;
    if (y_sat < lo_lim) y_sat = lo_lim;
    if (y_sat > hi_lim) y_sat = hi_lim;
  end

  assign result = y_sat[OUT_W-1:0];

endmodule

// ===== rtl/core/sfeq_checker.sv =====
module sfeq_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic m_axis_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // One item at a time: busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  // No result can be ready straight after an item is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> ##1 !$rose(m_axis_tvalid))
    else $error("result offered too early");

  // A new result is never offered straight out of the idle state
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without an item in flight");

endmodule

bind speaker_fir_equalizer_core sfeq_checker u_sfeq_checker (.*);
